@@ src/cfrc_pkg.sv @@
// shared types and constants for the cycled fan ramp controller
`default_nettype none

package cfrc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_MIN_SETPOINT   = 3'd0;
  localparam logic [2:0] CFG_MAX_SETPOINT   = 3'd1;
  localparam logic [2:0] CFG_FAN_MIN_DRIVE  = 3'd2;
  localparam logic [2:0] CFG_FAN_MAX_DRIVE  = 3'd3;
  localparam logic [2:0] CFG_RAMP_STEP      = 3'd4;
  localparam logic [2:0] CFG_ON_DURATION    = 3'd5;
  localparam logic [2:0] CFG_OFF_DURATION   = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // item kinds
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_CONTROL = 1'b1;

  // arithmetic widths
  localparam int MAG_W   = 15;  // magnitude of any scaled product
  localparam int PROD_W  = 17;  // signed product register
  localparam int RECIP_W = 17;  // reciprocal multiplier constant
  localparam int FULL_W  = 32;  // magnitude times reciprocal

  localparam int unsigned PCT_MAX           = 100;
  localparam int unsigned MILLIS_PER_SECOND = 1000;

  // divide by 99 through a rounded-up reciprocal, exact for MAG_W-bit numerators
  localparam int unsigned PWM_DIV   = 99;
  localparam int unsigned PWM_SHIFT = MAG_W + $clog2(PWM_DIV);
  localparam int unsigned PWM_RECIP = ((1 << PWM_SHIFT) + PWM_DIV - 1) / PWM_DIV;

  typedef struct packed {
    logic       kind;
    logic [7:0] knob_position;
  } item_t;

  typedef struct packed {
    logic [7:0]  pwm_value;
    logic [6:0]  output_percent;
    logic [6:0]  setpoint_percent;
    logic        cycle_enabled;
    logic [15:0] seconds_remaining;
  } result_t;

  typedef struct packed {
    logic [6:0]  min_setpoint;
    logic [6:0]  max_setpoint;
    logic [7:0]  fan_min_drive;
    logic [7:0]  fan_max_drive;
    logic [6:0]  ramp_step;
    logic [15:0] on_duration_sec;
    logic [15:0] off_duration_sec;
  } cfg_t;

  // datapath commands from the controller
  typedef struct packed {
    logic load_item;
    logic tick;
    logic knob_mul;
    logic knob_rec;
    logic knob_fin;
    logic ramp;
    logic pwm_mul;
    logic pwm_rec;
    logic out_load;
  } cmd_t;

endpackage

`default_nettype wire

@@ src/cycled_fan_ramp_controller_top.sv @@
// Cycled fan ramp controller. Each transfer on the input channel is either a
// one millisecond tick (kind 0) or a control step (kind 1) carrying a knob
// position, and each gives exactly one result transfer with the pwm byte,
// ramped output percent, setpoint percent, phase flag and seconds left in the
// phase. The controller walks one item at a time through the shared product
// register and reciprocal multiply stage (setpoint scaling for a control step,
// then pwm scaling), and takes no new item until the result is loaded. A
// finished result sits in the output register, so the next item is taken while
// it waits. Configuration must be written through the cfg port only while no
// item is in flight; the block itself does not enforce this. The port never
// pushes back.
`default_nettype none

module cycled_fan_ramp_controller_top #(
  parameter int KNOB_MIN = 0,
  parameter int KNOB_MAX = 24
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  cfrc_pkg::item_t                in_data,
  output logic                           out_valid,
  input  wire                            out_stall,
  output cfrc_pkg::result_t              out_data,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [cfrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [cfrc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cfrc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // configuration registers
  cfrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  cfrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_data.kind),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath
  cfrc_datapath #(
    .KNOB_MIN (KNOB_MIN),
    .KNOB_MAX (KNOB_MAX)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // ramped output stays within percent range
  a_output_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.output_percent <= 7'd100))
    else $error("output percent above 100");

  // setpoint stays within percent range
  a_setpoint_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.setpoint_percent <= 7'd100))
    else $error("setpoint percent above 100");

  // zero output drives zero pwm
  a_zero_pwm: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.output_percent == 7'd0)) |-> (out_data.pwm_value == 8'd0))
    else $error("nonzero pwm at zero output");

  // the input closes in the cycle after a transfer while the item is worked on
  a_result_after_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");
`endif

endmodule

`default_nettype wire

@@ src/cfrc_cfg_regs.sv @@
// configuration register file
`default_nettype none

module cfrc_cfg_regs (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire [cfrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [cfrc_pkg::CFG_DATA_W-1:0] cfg_data,
  output cfrc_pkg::cfg_t                cfg
);
  import cfrc_pkg::*;

  // writes must only happen while idle, which the block does not enforce; the port is always open
  assign cfg_ready = 1'b1;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_setpoint     <= 7'd0;
      cfg.max_setpoint     <= 7'd100;
      cfg.fan_min_drive    <= 8'd64;
      cfg.fan_max_drive    <= 8'd255;
      cfg.ramp_step        <= 7'd5;
      cfg.on_duration_sec  <= 16'd60;
      cfg.off_duration_sec <= 16'd60;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_SETPOINT:  cfg.min_setpoint     <= cfg_data[6:0];
        CFG_MAX_SETPOINT:  cfg.max_setpoint     <= cfg_data[6:0];
        CFG_FAN_MIN_DRIVE: cfg.fan_min_drive    <= cfg_data[7:0];
        CFG_FAN_MAX_DRIVE: cfg.fan_max_drive    <= cfg_data[7:0];
        CFG_RAMP_STEP:     cfg.ramp_step        <= cfg_data[6:0];
        CFG_ON_DURATION:   cfg.on_duration_sec  <= cfg_data;
        CFG_OFF_DURATION:  cfg.off_duration_sec <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/cfrc_ctrl.sv @@
// sequencing state machine and result handshake
`default_nettype none

module cfrc_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  wire             in_kind,
  output logic            out_valid,
  input  wire             out_stall,
  output cfrc_pkg::cmd_t  cmd
);
  import cfrc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TICK = 4'd1;
  localparam logic [3:0] S_KMUL = 4'd2;
  localparam logic [3:0] S_KREC = 4'd3;
  localparam logic [3:0] S_KFIN = 4'd4;
  localparam logic [3:0] S_RAMP = 4'd5;
  localparam logic [3:0] S_PMUL = 4'd6;
  localparam logic [3:0] S_PREC = 4'd7;
  localparam logic [3:0] S_PFIN = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       in_xfer;
  logic       out_free;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.load_item = 1'b1;
          state_next    = (in_kind == KIND_CONTROL) ? S_KMUL : S_TICK;
        end
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = S_PMUL;
      end
      S_KMUL: begin
        cmd.knob_mul = 1'b1;
        state_next   = S_KREC;
      end
      S_KREC: begin
        cmd.knob_rec = 1'b1;
        state_next   = S_KFIN;
      end
      S_KFIN: begin
        cmd.knob_fin = 1'b1;
        state_next   = S_RAMP;
      end
      S_RAMP: begin
        cmd.ramp   = 1'b1;
        state_next = S_PMUL;
      end
      S_PMUL: begin
        cmd.pwm_mul = 1'b1;
        state_next  = S_PREC;
      end
      S_PREC: begin
        cmd.pwm_rec = 1'b1;
        state_next  = S_PFIN;
      end
      S_PFIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/cfrc_datapath.sv @@
// timer, setpoint mapping, ramp and pwm scaling datapath
`default_nettype none

module cfrc_datapath #(
  parameter int KNOB_MIN = 0,
  parameter int KNOB_MAX = 24
) (
  input  wire               clk,
  input  wire               rst,
  input  cfrc_pkg::cmd_t    cmd,
  input  cfrc_pkg::cfg_t    cfg,
  input  cfrc_pkg::item_t   in_data,
  output cfrc_pkg::result_t out_data
);
  import cfrc_pkg::*;

  localparam bit SpanOk    = (KNOB_MAX > KNOB_MIN);
  localparam int KnobSpan  = SpanOk ? (KNOB_MAX - KNOB_MIN) : 1;
  localparam int KnobShift = MAG_W + $clog2(KnobSpan);
  localparam int KnobRecip = ((1 << KnobShift) + KnobSpan - 1) / KnobSpan;
  localparam logic [7:0] KnobLo = 8'(KNOB_MIN);
  localparam logic [7:0] KnobHi = 8'(KNOB_MAX);

  // block state
  logic        cycle_on;
  logic [6:0]  setpoint_reg;
  logic [6:0]  output_reg;
  logic [9:0]  millis_in_second;
  logic [15:0] seconds_elapsed;

  // working registers
  logic [7:0]               knob;
  logic signed [PROD_W-1:0] prod;
  logic [MAG_W-1:0]         quo;
  logic                     neg;

  // combinational helpers
  logic [7:0]               knob_clamped;
  logic [7:0]               knob_ofs;
  logic signed [7:0]        span_diff;
  logic signed [8:0]        drive_diff;
  logic [6:0]               out_m1;
  logic signed [PROD_W-1:0] knob_prod;
  logic signed [PROD_W-1:0] pwm_prod;
  logic [PROD_W-1:0]        mag;
  logic [RECIP_W-1:0]       rec_m;
  logic [FULL_W-1:0]        rec_full;
  logic [MAG_W-1:0]         quo_next;
  logic signed [PROD_W-1:0] quo_s;
  logic signed [PROD_W-1:0] sp_sum;
  logic [6:0]               sp_new;
  logic signed [PROD_W-1:0] pw_sum;
  logic [7:0]               pwm_new;
  logic [8:0]               o_plus;
  logic [8:0]               s_plus;
  logic [6:0]               ramp_new;
  logic [9:0]               ms_next;
  logic [15:0]              sec_next;
  logic [15:0]              dur_tick;
  logic [15:0]              dur_now;
  logic [15:0]              sec_rem;

  // knob clamp and span product
  always_comb begin
    if (knob < KnobLo) begin
      knob_clamped = KnobLo;
    end else if (knob > KnobHi) begin
      knob_clamped = KnobHi;
    end else begin
      knob_clamped = knob;
    end
    knob_ofs  = knob_clamped - KnobLo;
    span_diff = $signed({1'b0, cfg.max_setpoint}) - $signed({1'b0, cfg.min_setpoint});
    knob_prod = PROD_W'(signed'({1'b0, knob_ofs})) * PROD_W'(span_diff);
  end

  // drive span product
  always_comb begin
    out_m1     = output_reg - 7'd1;
    drive_diff = $signed({1'b0, cfg.fan_max_drive}) - $signed({1'b0, cfg.fan_min_drive});
    pwm_prod   = PROD_W'(signed'({1'b0, out_m1})) * PROD_W'(drive_diff);
  end

  // magnitude times reciprocal, shared by both divides
  always_comb begin
    mag      = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
    rec_m    = cmd.knob_rec ? RECIP_W'(KnobRecip) : RECIP_W'(PWM_RECIP);
    rec_full = FULL_W'(mag[MAG_W-1:0]) * FULL_W'(rec_m);
    quo_next = cmd.knob_rec ? MAG_W'(rec_full >> KnobShift) : MAG_W'(rec_full >> PWM_SHIFT);
  end

  // signed quotient, truncated toward zero
  assign quo_s = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});

  // setpoint offset and clamp
  always_comb begin
    if (SpanOk) begin
      sp_sum = quo_s + $signed({10'd0, cfg.min_setpoint});
    end else begin
      sp_sum = $signed({10'd0, cfg.min_setpoint});
    end
    if (sp_sum[PROD_W-1]) begin
      sp_new = 7'd0;
    end else if (sp_sum > $signed(PROD_W'(PCT_MAX))) begin
      sp_new = 7'(PCT_MAX);
    end else begin
      sp_new = sp_sum[6:0];
    end
  end

  // pwm offset and clamp
  always_comb begin
    pw_sum = quo_s + $signed({9'd0, cfg.fan_min_drive});
    if (output_reg == 7'd0) begin
      pwm_new = 8'd0;
    end else if (pw_sum[PROD_W-1]) begin
      pwm_new = 8'd0;
    end else if (pw_sum > $signed(PROD_W'(255))) begin
      pwm_new = 8'd255;
    end else begin
      pwm_new = pw_sum[7:0];
    end
  end

  // slew toward setpoint, or down toward zero in the off phase
  always_comb begin
    o_plus = {2'b00, output_reg} + {2'b00, cfg.ramp_step};
    s_plus = {2'b00, setpoint_reg} + {2'b00, cfg.ramp_step};
    if (cycle_on) begin
      if ((o_plus >= {2'b00, setpoint_reg}) && ({2'b00, output_reg} <= s_plus)) begin
        ramp_new = setpoint_reg;
      end else if (output_reg < setpoint_reg) begin
        ramp_new = output_reg + cfg.ramp_step;
      end else begin
        ramp_new = output_reg - cfg.ramp_step;
      end
    end else begin
      if ({1'b0, output_reg} <= cfg.fan_min_drive) begin
        ramp_new = 7'd0;
      end else if (output_reg <= cfg.ramp_step) begin
        ramp_new = 7'd0;
      end else begin
        ramp_new = output_reg - cfg.ramp_step;
      end
    end
  end

  // millisecond and second counters
  always_comb begin
    if ({1'b0, millis_in_second} == 11'(MILLIS_PER_SECOND - 1)) begin
      ms_next  = 10'd0;
      sec_next = (seconds_elapsed == 16'hFFFF) ? seconds_elapsed : seconds_elapsed + 16'd1;
    end else begin
      ms_next  = millis_in_second + 10'd1;
      sec_next = seconds_elapsed;
    end
    dur_tick = cycle_on ? cfg.on_duration_sec : cfg.off_duration_sec;
  end

  // time left in the current phase
  always_comb begin
    dur_now = cycle_on ? cfg.on_duration_sec : cfg.off_duration_sec;
    sec_rem = (dur_now > seconds_elapsed) ? dur_now - seconds_elapsed : 16'd0;
  end

  // block state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_on         <= 1'b1;
      setpoint_reg     <= 7'd0;
      output_reg       <= 7'd0;
      millis_in_second <= 10'd0;
      seconds_elapsed  <= 16'd0;
    end else begin
      if (cmd.tick) begin
        if (sec_next >= dur_tick) begin
          cycle_on         <= !cycle_on;
          millis_in_second <= 10'd0;
          seconds_elapsed  <= 16'd0;
        end else begin
          millis_in_second <= ms_next;
          seconds_elapsed  <= sec_next;
        end
      end
      if (cmd.knob_fin) begin
        setpoint_reg <= sp_new;
      end
      if (cmd.ramp) begin
        output_reg <= ramp_new;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      knob <= in_data.knob_position;
    end
    if (cmd.knob_mul) begin
      prod <= knob_prod;
    end else if (cmd.pwm_mul) begin
      prod <= pwm_prod;
    end
    if (cmd.knob_rec || cmd.pwm_rec) begin
      quo <= quo_next;
      neg <= prod[PROD_W-1];
    end
    if (cmd.out_load) begin
      out_data.pwm_value         <= pwm_new;
      out_data.output_percent    <= output_reg;
      out_data.setpoint_percent  <= setpoint_reg;
      out_data.cycle_enabled     <= cycle_on;
      out_data.seconds_remaining <= sec_rem;
    end
  end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// testbench for the cycled fan ramp controller: directed table, then randomized phases
`timescale 1ns / 1ps

module tb_top;
  import cfrc_pkg::*;

  localparam int KNOB_LO = 0;
  localparam int KNOB_HI = 24;
  localparam logic [2:0] CFG_SPARE = 3'd7;  // unmapped index, writes are dropped
  localparam int SETTLE_CYCLES = 12;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // one line of the directed table: a register write or an item
  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [15:0] reg_val;
    item_t       item;
    bit          known;
    result_t     want;
  } fan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  item_t                 in_data;
  logic                  out_valid;
  logic                  out_stall;
  result_t               out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // fan model state and register copy
  cfg_t        cfg_model;
  logic        cyc_on;
  logic [6:0]  sp_q;
  logic [6:0]  out_q;
  logic [9:0]  ms_q;
  logic [15:0] sec_q;

  result_t pending_results[$];
  int      mismatches;
  int      send_idle_pct;
  int      recv_stall_pct;

  cycled_fan_ramp_controller_top #(
    .KNOB_MIN (KNOB_LO),
    .KNOB_MAX (KNOB_HI)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // predict the result of one item and advance the model
  task automatic predict_fan_result(input item_t it, output result_t res);
    int          k;
    int          pct;
    int          o;
    int          s;
    int          st;
    int          pwm;
    logic [15:0] dur;
    if (it.kind == KIND_TICK) begin
      // millisecond tick, second rollover, phase expiry
      ms_q = ms_q + 10'd1;
      if (ms_q >= MILLIS_PER_SECOND) begin
        ms_q = '0;
        if (sec_q != 16'hFFFF) sec_q = sec_q + 16'd1;
      end
      dur = cyc_on ? cfg_model.on_duration_sec : cfg_model.off_duration_sec;
      if (sec_q >= dur) begin
        cyc_on = ~cyc_on;
        ms_q   = '0;
        sec_q  = '0;
      end
    end else begin
      // knob clamp and linear map to percent
      k = int'(it.knob_position);
      if (KNOB_HI <= KNOB_LO) begin
        pct = int'(cfg_model.min_setpoint);
      end else begin
        if (k < KNOB_LO) k = KNOB_LO;
        if (k > KNOB_HI) k = KNOB_HI;
        pct = (k - KNOB_LO) * (int'(cfg_model.max_setpoint) - int'(cfg_model.min_setpoint))
              / (KNOB_HI - KNOB_LO) + int'(cfg_model.min_setpoint);
      end
      if (pct < 0) pct = 0;
      if (pct > int'(PCT_MAX)) pct = int'(PCT_MAX);
      sp_q = 7'(pct);
      // slew toward setpoint, or toward zero in the off phase
      o  = int'(out_q);
      s  = int'(sp_q);
      st = int'(cfg_model.ramp_step);
      if (cyc_on) begin
        if (o >= s - st && o <= s + st) o = s;
        else if (o < s) o = o + st;
        else o = o - st;
      end else begin
        if (o <= int'(cfg_model.fan_min_drive)) o = 0;
        else if (o <= st) o = 0;
        else o = o - st;
      end
      out_q = 7'(o);
    end
    // percent to pwm byte
    if (out_q == '0) begin
      pwm = 0;
    end else begin
      pwm = (int'(out_q) - 1) * (int'(cfg_model.fan_max_drive) - int'(cfg_model.fan_min_drive))
            / int'(PWM_DIV) + int'(cfg_model.fan_min_drive);
      if (pwm < 0) pwm = 0;
      if (pwm > 255) pwm = 255;
    end
    dur = cyc_on ? cfg_model.on_duration_sec : cfg_model.off_duration_sec;
    res.pwm_value         = 8'(pwm);
    res.output_percent    = out_q;
    res.setpoint_percent  = sp_q;
    res.cycle_enabled     = cyc_on;
    res.seconds_remaining = (dur > sec_q) ? dur - sec_q : 16'd0;
  endtask

  function automatic fan_row_t item_row(input logic kind, input logic [7:0] knob);
    fan_row_t r;
    r = '{default: '0};
    r.item.kind          = kind;
    r.item.knob_position = knob;
    return r;
  endfunction

  function automatic fan_row_t known_row(input logic kind, input logic [7:0] knob,
                                         input result_t want);
    fan_row_t r;
    r = item_row(kind, knob);
    r.known = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic fan_row_t cfg_row(input logic [2:0] idx, input logic [15:0] val);
    fan_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [15:0] pick_duration();
    return ($urandom_range(99) < 40) ? 16'd0 : 16'($urandom_range(65535, 1));
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 84;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 84;
      end
      default: begin
        send_idle_pct = 33;
        recv_stall_pct = 33;
      end
    endcase
  endtask

  // one item transfer; entered and left at a falling edge
  task automatic send_item(input item_t it, input bit known, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_fan_result(it, predicted);
    pending_results.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  // one register write transfer
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MIN_SETPOINT:  cfg_model.min_setpoint     = val[6:0];
      CFG_MAX_SETPOINT:  cfg_model.max_setpoint     = val[6:0];
      CFG_FAN_MIN_DRIVE: cfg_model.fan_min_drive    = val[7:0];
      CFG_FAN_MAX_DRIVE: cfg_model.fan_max_drive    = val[7:0];
      CFG_RAMP_STEP:     cfg_model.ramp_step        = val[6:0];
      CFG_ON_DURATION:   cfg_model.on_duration_sec  = val;
      CFG_OFF_DURATION:  cfg_model.off_duration_sec = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_cfg(input cfg_t c);
    write_reg(CFG_MIN_SETPOINT, 16'(c.min_setpoint));
    write_reg(CFG_MAX_SETPOINT, 16'(c.max_setpoint));
    write_reg(CFG_FAN_MIN_DRIVE, 16'(c.fan_min_drive));
    write_reg(CFG_FAN_MAX_DRIVE, 16'(c.fan_max_drive));
    write_reg(CFG_RAMP_STEP, 16'(c.ramp_step));
    write_reg(CFG_ON_DURATION, c.on_duration_sec);
    write_reg(CFG_OFF_DURATION, c.off_duration_sec);
    if ($urandom_range(1) == 1) write_reg(CFG_SPARE, 16'($urandom));
  endtask

  // wait until every expected result has come back, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result at %0t: pwm=%0d out=%0d sp=%0d en=%0d rem=%0d",
                   $time, out_data.pwm_value, out_data.output_percent,
                   out_data.setpoint_percent, out_data.cycle_enabled,
                   out_data.seconds_remaining);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.pwm_value !== want.pwm_value ||
            out_data.output_percent !== want.output_percent ||
            out_data.setpoint_percent !== want.setpoint_percent ||
            out_data.cycle_enabled !== want.cycle_enabled ||
            out_data.seconds_remaining !== want.seconds_remaining) begin
          if (mismatches < 10)
            $display("bad result at %0t: want pwm=%0d out=%0d sp=%0d en=%0d rem=%0d",
                     $time, want.pwm_value, want.output_percent, want.setpoint_percent,
                     want.cycle_enabled, want.seconds_remaining, "\n",
                     "                      got  pwm=%0d out=%0d sp=%0d en=%0d rem=%0d",
                     out_data.pwm_value, out_data.output_percent,
                     out_data.setpoint_percent, out_data.cycle_enabled,
                     out_data.seconds_remaining);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin
    fan_row_t script[$];
    cfg_t     phase_cfg;
    item_t    it;
    int       ph;
    int       n;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    cfg_model      = '{7'd0, 7'd100, 8'd64, 8'd255, 7'd5, 16'd60, 16'd60};
    cyc_on         = 1'b1;
    sp_q           = '0;
    out_q          = '0;
    ms_q           = '0;
    sec_q          = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table: reset state, knob extremes and clamping
    script.push_back(known_row(KIND_TICK, 8'd0, '{8'd0, 7'd0, 7'd0, 1'b1, 16'd60}));
    // tick ignores the knob
    script.push_back(known_row(KIND_TICK, 8'd255, '{8'd0, 7'd0, 7'd0, 1'b1, 16'd60}));
    script.push_back(known_row(KIND_CONTROL, 8'd0, '{8'd0, 7'd0, 7'd0, 1'b1, 16'd60}));
    script.push_back(item_row(KIND_CONTROL, 8'd255));
    script.push_back(item_row(KIND_CONTROL, 8'd24));
    script.push_back(item_row(KIND_CONTROL, 8'd25));
    script.push_back(item_row(KIND_CONTROL, 8'd12));
    // full step snaps straight to a full setpoint
    script.push_back(cfg_row(CFG_RAMP_STEP, 16'd100));
    script.push_back(known_row(KIND_CONTROL, 8'd24, '{8'd255, 7'd100, 7'd100, 1'b1, 16'd60}));
    // inverted setpoint span, truncation of a negative slope
    script.push_back(cfg_row(CFG_MIN_SETPOINT, 16'd100));
    script.push_back(cfg_row(CFG_MAX_SETPOINT, 16'd0));
    script.push_back(item_row(KIND_CONTROL, 8'd7));
    // inverted drive span
    script.push_back(cfg_row(CFG_FAN_MIN_DRIVE, 16'd255));
    script.push_back(cfg_row(CFG_FAN_MAX_DRIVE, 16'd0));
    script.push_back(item_row(KIND_CONTROL, 8'd0));
    // zero on duration flips on the next tick, off ramp below the cut threshold
    script.push_back(cfg_row(CFG_ON_DURATION, 16'd0));
    script.push_back(item_row(KIND_TICK, 8'h5A));
    script.push_back(item_row(KIND_CONTROL, 8'd24));
    // back on through a zero off duration, spare index write dropped
    script.push_back(cfg_row(CFG_ON_DURATION, 16'hFFFF));
    script.push_back(cfg_row(CFG_OFF_DURATION, 16'd0));
    script.push_back(cfg_row(CFG_FAN_MIN_DRIVE, 16'd10));
    script.push_back(cfg_row(CFG_RAMP_STEP, 16'd30));
    script.push_back(cfg_row(CFG_SPARE, 16'hFFFF));
    script.push_back(item_row(KIND_TICK, 8'd0));
    script.push_back(item_row(KIND_CONTROL, 8'd0));
    script.push_back(item_row(KIND_CONTROL, 8'd0));
    // off ramp by steps, saturating at zero
    script.push_back(cfg_row(CFG_ON_DURATION, 16'd0));
    script.push_back(item_row(KIND_TICK, 8'd0));
    script.push_back(item_row(KIND_CONTROL, 8'd0));
    script.push_back(item_row(KIND_CONTROL, 8'd0));
    // zero ramp step only moves by snapping
    script.push_back(cfg_row(CFG_RAMP_STEP, 16'd0));
    script.push_back(cfg_row(CFG_ON_DURATION, 16'hFFFF));
    script.push_back(item_row(KIND_TICK, 8'd0));
    script.push_back(item_row(KIND_CONTROL, 8'd0));
    script.push_back(item_row(KIND_CONTROL, 8'd24));

    set_idle(IDLE_NONE);
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        in_valid <= 1'b0;
        wait_idle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_item(script[i].item, script[i].known, script[i].want);
      end
    end

    // random phases, each with its own registers and idle pattern
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: phase_cfg = '{7'd0, 7'd0, 8'd0, 8'd0, 7'd1, 16'd1, 16'd1};
        1: phase_cfg = '{7'd100, 7'd100, 8'd255, 8'd255, 7'd100, 16'hFFFF, 16'hFFFF};
        default: begin
          phase_cfg.min_setpoint     = 7'($urandom_range(100));
          phase_cfg.max_setpoint     = 7'($urandom_range(100));
          phase_cfg.fan_min_drive    = 8'($urandom_range(255));
          phase_cfg.fan_max_drive    = 8'($urandom_range(255));
          phase_cfg.ramp_step        = 7'($urandom_range(100, 1));
          phase_cfg.on_duration_sec  = pick_duration();
          phase_cfg.off_duration_sec = pick_duration();
        end
      endcase
      in_valid <= 1'b0;
      wait_idle();
      program_cfg(phase_cfg);
      set_idle(idle_mode_t'(ph % 4));
      for (n = 0; n < 72; n++) begin
        it.kind          = ($urandom_range(99) < 40) ? KIND_TICK : KIND_CONTROL;
        it.knob_position = ($urandom_range(99) < 60) ? 8'($urandom_range(KNOB_HI + 2))
                                                     : 8'($urandom);
        send_item(it, 1'b0, '0);
      end
    end

    // drain and report
    in_valid <= 1'b0;
    wait_idle();
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
